### rtl/bshe_pkg.sv
`timescale 1ns / 1ps

package bshe_pkg;

    localparam logic [31:0] FNV_OFFSET    = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME     = 32'h01000193;
    localparam logic [7:0]  STRING_TYPE   = 8'h10;
    localparam logic [2:0]  EV_MARKER_LEN = 3'd6;
    localparam logic [2:0]  MU_MARKER_LEN = 3'd5;
    localparam logic        KIND_EVENTS   = 1'b0;
    localparam logic        KIND_MUSIC    = 1'b1;

    typedef enum logic [12:0] {
        PH_SEARCH   = 13'b0000000000001,
        PH_EV_SIZE  = 13'b0000000000010,
        PH_EV_COUNT = 13'b0000000000100,
        PH_MU_TYPE  = 13'b0000000001000,
        PH_MU_SIZE  = 13'b0000000010000,
        PH_MU_COUNT = 13'b0000000100000,
        PH_MU_NAME  = 13'b0000001000000,
        PH_MU_BTYPE = 13'b0000010000000,
        PH_EV_LEN   = 13'b0000100000000,
        PH_EV_DATA  = 13'b0001000000000,
        PH_MU_LEN   = 13'b0010000000000,
        PH_MU_DATA  = 13'b0100000000000,
        PH_FAILED   = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic [31:0] name_hash;
        logic [15:0] name_len;
        logic        hash_valid;
        logic        stream_done;
        logic        malformed;
    } t_result;

    // Marker byte at position idx for the selected container kind.
    function automatic logic [7:0] marker_byte(input logic kind, input logic [2:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if (kind == KIND_MUSIC) begin
            case (idx)
                3'd0:    v = 8'hD4;
                3'd1:    v = 8'h4F;
                3'd2:    v = 8'h9C;
                3'd3:    v = 8'h9F;
                3'd4:    v = 8'h83;
                default: v = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0:    v = 8'h84;
                3'd1:    v = 8'hE3;
                3'd2:    v = 8'hD8;
                3'd3:    v = 8'h12;
                3'd4:    v = 8'h80;
                3'd5:    v = 8'h10;
                default: v = 8'h00;
            endcase
        end
        return v;
    endfunction

endpackage

### rtl/bshe_parser.sv
`timescale 1ns / 1ps

module bshe_parser import bshe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_cfg_write,
    input  logic       i_cfg_kind,
    output logic       o_emit,
    output t_result    o_result
);

    logic        r_kind;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_matched, n_matched;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_entries, n_entries;
    logic [15:0] r_left, n_left;
    logic [15:0] r_cur_len, n_cur_len;
    logic [31:0] r_hash, n_hash;
    logic        r_stopped, n_stopped;
    logic        r_error, n_error;

    logic [31:0] gathered;
    logic        gather2_done;
    logic        gather4_done;
    logic [31:0] folded;
    logic [31:0] hash_prod;
    logic [31:0] hash_step;
    logic [15:0] left_m1;
    logic [31:0] entries_m1;
    logic [2:0]  marker_len;
    logic [2:0]  matched_p1;
    logic        done;
    t_phase      done_next;

    assign gathered     = r_acc | ({24'd0, i_data_byte} << {r_idx, 3'b000});
    assign gather2_done = (r_idx != 2'd0);
    assign gather4_done = (r_idx == 2'd3);
    assign left_m1      = r_left - 16'd1;
    assign entries_m1   = r_entries - 32'd1;
    assign marker_len   = (r_kind == KIND_MUSIC) ? MU_MARKER_LEN : EV_MARKER_LEN;
    assign hash_prod    = r_hash * FNV_PRIME;
    assign hash_step    = hash_prod ^ folded;

    // Upper case folds to lower; high bytes enter the hash sign-extended.
    always_comb begin
        if (i_data_byte > 8'd64 && i_data_byte < 8'd91) begin
            folded = {24'd0, i_data_byte + 8'd32};
        end else if (i_data_byte[7]) begin
            folded = {24'hFFFFFF, i_data_byte};
        end else begin
            folded = {24'd0, i_data_byte};
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_matched = r_matched;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_entries = r_entries;
        n_left    = r_left;
        n_cur_len = r_cur_len;
        n_hash    = r_hash;
        n_stopped = r_stopped;
        n_error   = r_error;
        done      = 1'b0;
        done_next = PH_EV_LEN;
        matched_p1 = 3'd0;
        o_result  = '0;

        unique case (r_phase)
            PH_SEARCH: begin
                if (r_matched < marker_len && i_data_byte == marker_byte(r_kind, r_matched)) begin
                    matched_p1 = r_matched + 3'd1;
                end else if (i_data_byte == marker_byte(r_kind, 3'd0)) begin
                    matched_p1 = 3'd1;
                end else begin
                    matched_p1 = 3'd0;
                end
                n_matched = matched_p1;
                if (matched_p1 == marker_len) begin
                    n_matched = 3'd0;
                    n_idx     = 2'd0;
                    n_acc     = '0;
                    n_phase   = (r_kind == KIND_MUSIC) ? PH_MU_TYPE : PH_EV_SIZE;
                end
            end
            PH_EV_SIZE, PH_MU_SIZE, PH_MU_NAME: begin
                n_acc = gathered;
                n_idx = r_idx + 2'd1;
                if (gather4_done) begin
                    n_idx = 2'd0;
                    n_acc = '0;
                    n_phase = (r_phase == PH_EV_SIZE) ? PH_EV_COUNT :
                              (r_phase == PH_MU_SIZE) ? PH_MU_COUNT : PH_MU_BTYPE;
                end
            end
            PH_EV_COUNT: begin
                n_acc = gathered;
                n_idx = r_idx + 2'd1;
                if (gather4_done) begin
                    n_idx     = 2'd0;
                    n_acc     = '0;
                    n_entries = gathered;
                    n_phase   = (gathered != 32'd0) ? PH_EV_LEN : PH_SEARCH;
                end
            end
            PH_MU_TYPE: begin
                n_acc = gathered;
                n_idx = r_idx + 2'd1;
                if (gather4_done) begin
                    n_idx   = 2'd0;
                    n_acc   = '0;
                    n_phase = (gathered != 32'd0) ? PH_MU_SIZE : PH_SEARCH;
                end
            end
            PH_MU_COUNT: begin
                n_acc = gathered;
                n_idx = r_idx + 2'd1;
                if (gather2_done) begin
                    n_idx     = 2'd0;
                    n_acc     = '0;
                    n_entries = {16'd0, gathered[15:0]};
                    n_phase   = (gathered[15:0] != 16'd0) ? PH_MU_NAME : PH_SEARCH;
                end
            end
            PH_MU_BTYPE: begin
                if (i_data_byte == STRING_TYPE) begin
                    n_phase = PH_MU_LEN;
                end else begin
                    n_error = 1'b1;
                    n_phase = PH_FAILED;
                end
            end
            PH_EV_LEN, PH_MU_LEN: begin
                n_acc = gathered;
                n_idx = r_idx + 2'd1;
                done_next = (r_phase == PH_EV_LEN) ? PH_EV_LEN : PH_MU_NAME;
                if (gather2_done) begin
                    n_idx     = 2'd0;
                    n_acc     = '0;
                    n_cur_len = gathered[15:0];
                    n_left    = gathered[15:0];
                    n_hash    = FNV_OFFSET;
                    n_stopped = 1'b0;
                    if (gathered[15:0] == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = (r_phase == PH_EV_LEN) ? PH_EV_DATA : PH_MU_DATA;
                    end
                end
            end
            PH_EV_DATA, PH_MU_DATA: begin
                done_next = (r_phase == PH_EV_DATA) ? PH_EV_LEN : PH_MU_NAME;
                if (!r_stopped) begin
                    if (i_data_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_hash = hash_step;
                    end
                end
                n_left = left_m1;
                done   = (left_m1 == 16'd0);
            end
            PH_FAILED: begin
                n_phase = PH_FAILED;
            end
            default: begin
                n_phase = PH_FAILED;
            end
        endcase

        if (done) begin
            o_result.name_hash  = n_hash;
            o_result.name_len   = n_cur_len;
            o_result.hash_valid = 1'b1;
            n_hash    = FNV_OFFSET;
            n_stopped = 1'b0;
            n_entries = entries_m1;
            n_phase   = (entries_m1 != 32'd0) ? done_next : PH_SEARCH;
        end

        o_result.stream_done = i_last_byte;
        o_result.malformed   = i_last_byte && (n_error || n_phase != PH_SEARCH);
        o_emit = done || i_last_byte;

        // The final byte of a file clears the parse state but keeps the kind.
        if (i_last_byte) begin
            n_phase   = PH_SEARCH;
            n_matched = 3'd0;
            n_idx     = 2'd0;
            n_acc     = '0;
            n_entries = '0;
            n_left    = '0;
            n_cur_len = '0;
            n_hash    = FNV_OFFSET;
            n_stopped = 1'b0;
            n_error   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_EVENTS;
            r_phase   <= PH_SEARCH;
            r_matched <= 3'd0;
            r_idx     <= 2'd0;
            r_acc     <= '0;
            r_entries <= '0;
            r_left    <= '0;
            r_cur_len <= '0;
            r_hash    <= FNV_OFFSET;
            r_stopped <= 1'b0;
            r_error   <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase   <= n_phase;
                r_idx     <= n_idx;
                r_acc     <= n_acc;
                r_entries <= n_entries;
                r_left    <= n_left;
                r_cur_len <= n_cur_len;
                r_hash    <= n_hash;
                r_stopped <= n_stopped;
                r_error   <= n_error;
            end
            // A register write takes effect after a byte accepted in the same cycle.
            if (i_cfg_write) begin
                r_kind    <= i_cfg_kind;
                r_matched <= 3'd0;
            end else if (i_accept) begin
                r_matched <= n_matched;
            end
        end
    end

endmodule

### rtl/bshe_out_reg.sv
`timescale 1ns / 1ps

module bshe_out_reg import bshe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_can_accept
);

    logic    r_valid;
    t_result r_result;

    // A new word may enter when the register is empty or drains this cycle.
    assign o_can_accept = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/bin_string_hash_extractor_unit.sv
`timescale 1ns / 1ps
// String hash extractor for a binary property file streamed one byte per word.
// The slave stream carries one file byte in tdata and marks the final byte of
// the file with tlast. The block looks for the marker chosen by the one-bit
// configuration register, parses the structure behind it and, for every string,
// sends one master word with the case-folded FNV-1 hash and declared length.
// The final byte of a file always produces a word with tlast set; tuser[1]
// then tells whether the file was malformed or truncated.
// The configuration channel is always ready; the user must write it only while
// idle; the block does not enforce it. Throughput is one byte per cycle while
// the output register can take a word: the parser state and hash update (one
// constant multiply and an XOR) are combinational, registered on each accepted
// byte. Its result word, held in the output register, is offered the next cycle.
// Reset returns the parser to marker search and selects the events marker.
// When the receiver stalls, the held word stays put and s_axis_tready drops
// until the output register is taken, so no byte or result is lost.
module bin_string_hash_extractor_unit import bshe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] name_hash, [47:32] name_len
    output logic [1:0]  m_axis_tuser,   // [0] hash_valid, [1] malformed
    output logic        m_axis_tlast,   // stream_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // container_kind
);

    logic    accept;
    logic    emit;
    logic    can_accept;
    t_result result;
    t_result held;

    assign s_axis_tready = can_accept;
    assign accept        = s_axis_tvalid && can_accept;
    assign o_cfg_ready   = 1'b1;

    bshe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_kind  (i_cfg_data),
        .o_emit      (emit),
        .o_result    (result)
    );

    bshe_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && emit),
        .i_result     (result),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_result     (held),
        .o_can_accept (can_accept)
    );

    assign m_axis_tdata = {held.name_len, held.name_hash};
    assign m_axis_tuser = {held.malformed, held.hash_valid};
    assign m_axis_tlast = held.stream_done;

endmodule
